// ===== sv/tdpc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the trial-division prime counter.
// Used by tdpc_ctrl, tdpc_datapath and trial_division_prime_counter.
package tdpc_pkg;

  localparam int DEF_VALUE_WIDTH = 32;
  localparam int DEF_COUNT_WIDTH = 32;
  localparam int CAND_WIDTH      = 32;
  localparam int COUNT_OUT_WIDTH = 32;
  localparam int EVEN_PRIME      = 2;
  localparam int FIRST_DIVISOR   = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_BOUND,
    ST_DIVIDE,
    ST_TEST,
    ST_EMIT
  } tdpc_state_t;

  typedef struct packed {
    logic load;
    logic start_div;
    logic div_step;
    logic next_div;
    logic finish;
    logic prime;
  } tdpc_cmd_t;

  typedef struct packed {
    logic neg;
    logic le_one;
    logic is_two;
    logic even;
    logic bound_ok;
    logic bit_last;
    logic rem_zero;
    logic out_busy;
  } tdpc_status_t;

endpackage

// ===== sv/tdpc_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the trial-division prime counter.
// Depends on tdpc_pkg; drives tdpc_datapath through command and status structs.
module tdpc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tdpc_pkg::tdpc_status_t status,
  output tdpc_pkg::tdpc_cmd_t    cmd
);
  import tdpc_pkg::*;

  tdpc_state_t state_r, state_nxt;
  logic        verdict_r, verdict_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    verdict_nxt = verdict_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        if (status.neg || status.le_one) begin
          verdict_nxt = 1'b0;
          state_nxt   = ST_EMIT;
        end else if (status.is_two) begin
          verdict_nxt = 1'b1;
          state_nxt   = ST_EMIT;
        end else if (status.even) begin
          verdict_nxt = 1'b0;
          state_nxt   = ST_EMIT;
        end else begin
          state_nxt = ST_BOUND;
        end
      end
      ST_BOUND: begin
        if (status.bound_ok) begin
          state_nxt = ST_DIVIDE;
        end else begin
          verdict_nxt = 1'b1;
          state_nxt   = ST_EMIT;
        end
      end
      ST_DIVIDE: begin
        if (status.bit_last) begin
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (status.rem_zero) begin
          verdict_nxt = 1'b0;
          state_nxt   = ST_EMIT;
        end else begin
          state_nxt = ST_BOUND;
        end
      end
      ST_EMIT: begin
        if (!status.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.prime = verdict_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_BOUND: begin
        cmd.start_div = status.bound_ok;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      ST_TEST: begin
        cmd.next_div = !status.rem_zero;
      end
      ST_EMIT: begin
        cmd.finish = !status.out_busy;
      end
      default: begin
        cmd.load = 1'b0;
      end
    endcase
  end

  a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.start_div, cmd.div_step, cmd.next_div, cmd.finish}))
    else $error("more than one datapath command in a cycle");

endmodule

// ===== sv/tdpc_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: candidate, divisor and square registers, bit-serial remainder unit,
// running count and output register. Depends on tdpc_pkg.
module tdpc_datapath #(
  parameter int VALUE_WIDTH = tdpc_pkg::DEF_VALUE_WIDTH,
  parameter int COUNT_WIDTH = tdpc_pkg::DEF_COUNT_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic signed [tdpc_pkg::CAND_WIDTH-1:0] in_candidate,
  input  logic                                  in_first_of_run,
  input  tdpc_pkg::tdpc_cmd_t                   cmd,
  output tdpc_pkg::tdpc_status_t                status,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic                                  out_is_prime,
  output logic [tdpc_pkg::COUNT_OUT_WIDTH-1:0]  out_prime_count
);
  import tdpc_pkg::*;

  localparam int SQ_WIDTH  = VALUE_WIDTH + 2;
  localparam int BIT_WIDTH = $clog2(VALUE_WIDTH);
  localparam int FIRST_SQ  = FIRST_DIVISOR * FIRST_DIVISOR;

  logic [VALUE_WIDTH-1:0] value_r;
  logic                   first_r;
  logic [VALUE_WIDTH-1:0] div_r;
  logic [SQ_WIDTH-1:0]    sq_r;
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0] shift_r;
  logic [BIT_WIDTH-1:0]   bitcnt_r;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt, count_base;
  logic                   out_valid_r;
  logic                   out_is_prime_r;
  logic [COUNT_OUT_WIDTH-1:0] out_count_r;

  logic [63:0]            cand_ext;
  logic [63:0]            count_ext;
  logic [VALUE_WIDTH:0]   trial, div_ext, trial_diff;

  assign cand_ext = {{(64 - CAND_WIDTH){in_candidate[CAND_WIDTH-1]}}, in_candidate};

  assign trial      = {rem_r, shift_r[VALUE_WIDTH-1]};
  assign div_ext    = {1'b0, div_r};
  assign trial_diff = trial - div_ext;
  assign rem_nxt    = (trial >= div_ext) ? trial_diff[VALUE_WIDTH-1:0]
                                         : trial[VALUE_WIDTH-1:0];

  assign count_base = first_r ? '0 : count_r;
  assign count_nxt  = (cmd.prime && (count_base != '1)) ? count_base + 1'b1 : count_base;
  assign count_ext  = 64'(count_nxt);

  assign status.neg      = value_r[VALUE_WIDTH-1];
  assign status.le_one   = value_r <= VALUE_WIDTH'(1);
  assign status.is_two   = value_r == VALUE_WIDTH'(EVEN_PRIME);
  assign status.even     = !value_r[0];
  assign status.bound_ok = sq_r <= {2'b00, value_r};
  assign status.bit_last = bitcnt_r == BIT_WIDTH'(VALUE_WIDTH - 1);
  assign status.rem_zero = rem_r == '0;
  assign status.out_busy = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= cand_ext[VALUE_WIDTH-1:0];
      first_r <= in_first_of_run;
      div_r   <= VALUE_WIDTH'(FIRST_DIVISOR);
      sq_r    <= SQ_WIDTH'(FIRST_SQ);
    end else if (cmd.next_div) begin
      div_r <= div_r + VALUE_WIDTH'(2);
      sq_r  <= sq_r + ({2'b00, div_r} << 2) + SQ_WIDTH'(4);
    end
    if (cmd.start_div) begin
      rem_r    <= '0;
      shift_r  <= value_r;
      bitcnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r    <= rem_nxt;
      shift_r  <= shift_r << 1;
      bitcnt_r <= bitcnt_r + 1'b1;
    end
    if (cmd.finish) begin
      out_is_prime_r <= cmd.prime;
      out_count_r    <= count_ext[COUNT_OUT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_prime    = out_is_prime_r;
  assign out_prime_count = out_count_r;

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && cmd.prime && !first_r && (count_r != '1)
    |=> count_r == COUNT_WIDTH'($past(count_r) + 1'b1))
    else $error("running count did not advance on a prime");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.div_step) |-> rem_r < div_r)
    else $error("partial remainder not below divisor");

  a_div_odd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> div_r[0] && (div_r >= VALUE_WIDTH'(FIRST_DIVISOR)))
    else $error("trial divisor not an odd value of three or more");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_valid_r && !out_ready))
    else $error("result written over a transaction still waiting");

endmodule

// ===== sv/trial_division_prime_counter.sv =====
`timescale 1ns / 1ps
// Trial-division prime counter: top level joining tdpc_ctrl and tdpc_datapath.
// Depends on tdpc_pkg.
//
// Input channel (in_valid/in_ready): one candidate per transaction, with
// in_first_of_run clearing the running count before the candidate counts.
// Result channel (out_valid/out_ready): one transaction per candidate carrying
// the prime flag and the saturating running count after that candidate.
// Negatives, 0, 1, 2 and even values are settled without trial division;
// otherwise the odd divisors 3, 5, 7, ... are tried while their square does
// not exceed the candidate (at most about sqrt(candidate) / 2 of them), and
// the search stops at the first divisor that is a factor. Each divisor costs
// one bound check, a pass of the one-bit-a-cycle remainder unit and one zero
// test; that unit sets the rate.
// One candidate is in work at a time; the next is taken once its result sits
// in the output register, so a stalled receiver holds at most one result
// while the next candidate runs, and the block waits before writing another.
// Reset (rst_n low at a clock edge) empties the output register, clears the
// running count and returns the sequencer to idle.
module trial_division_prime_counter #(
  parameter int VALUE_WIDTH = tdpc_pkg::DEF_VALUE_WIDTH,
  parameter int COUNT_WIDTH = tdpc_pkg::DEF_COUNT_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [tdpc_pkg::CAND_WIDTH-1:0] in_candidate,
  input  logic                                   in_first_of_run,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_is_prime,
  output logic [tdpc_pkg::COUNT_OUT_WIDTH-1:0]   out_prime_count
);
  import tdpc_pkg::*;

  tdpc_cmd_t    cmd;
  tdpc_status_t status;

  tdpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tdpc_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_candidate    (in_candidate),
    .in_first_of_run (in_first_of_run),
    .cmd             (cmd),
    .status          (status),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_is_prime    (out_is_prime),
    .out_prime_count (out_prime_count)
  );

endmodule
